FILE: hw/rtl/ecd_pkg.sv
// elevator dispatch package: codes, widths and search helpers
`timescale 1ns / 1ps
`default_nettype none
package ecd_pkg;

  localparam int FLOOR_COUNT = 16;
  localparam int FLOOR_W = 4;
  localparam logic [FLOOR_W-1:0] TOP_FLOOR_INDEX = 4'd15;

  localparam logic [1:0] CMD_CAR       = 2'd0;
  localparam logic [1:0] CMD_HALL_UP   = 2'd1;
  localparam logic [1:0] CMD_HALL_DOWN = 2'd2;
  localparam logic [1:0] CMD_TICK      = 2'd3;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_MOVING  = 3'd1;
  localparam logic [2:0] PH_OPENING = 3'd2;
  localparam logic [2:0] PH_OPEN    = 3'd3;
  localparam logic [2:0] PH_CLOSING = 3'd4;

  localparam logic [1:0] DIR_IDLE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  localparam logic [1:0] CFG_LOWEST     = 2'd0;
  localparam logic [1:0] CFG_HIGHEST    = 2'd1;
  localparam logic [1:0] CFG_DOOR_TICKS = 2'd2;

  typedef struct packed {
    logic latch;
    logic exec;
    logic search;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic need_search;
    logic out_free;
  } dp_status_t;

  function automatic logic [FLOOR_W-1:0] lowest_set(input logic [FLOOR_COUNT-1:0] v);
    logic [FLOOR_W-1:0] r;
    r = '0;
    for (int i = FLOOR_COUNT - 1; i >= 0; i--) begin
      if (v[i]) r = FLOOR_W'(i);
    end
    return r;
  endfunction

  function automatic logic [FLOOR_W-1:0] highest_set(input logic [FLOOR_COUNT-1:0] v);
    logic [FLOOR_W-1:0] r;
    r = '0;
    for (int i = 0; i < FLOOR_COUNT; i++) begin
      if (v[i]) r = FLOOR_W'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ecd_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface ecd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [3:0] floor;
  logic [3:0] position_floor;
  logic       at_target;

  modport source (output valid, command, floor, position_floor, at_target, input ready);
  modport sink (input valid, command, floor, position_floor, at_target, output ready);
endinterface

interface ecd_out_if;
  logic        valid;
  logic        ready;
  logic        call_accepted;
  logic [2:0]  motion_phase;
  logic [1:0]  travel_direction;
  logic [3:0]  current_floor_out;
  logic [3:0]  target_floor_out;
  logic        target_valid;
  logic [15:0] pending_calls;

  modport source (output valid, call_accepted, motion_phase, travel_direction,
                  current_floor_out, target_floor_out, target_valid, pending_calls,
                  input ready);
  modport sink (input valid, call_accepted, motion_phase, travel_direction,
                current_floor_out, target_floor_out, target_valid, pending_calls,
                output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/ecd_ctrl.sv
// dispatch controller state machine
`timescale 1ns / 1ps
`default_nettype none
module ecd_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire ecd_pkg::dp_status_t status_i,
  output ecd_pkg::dp_cmd_t        cmd_o
);
  import ecd_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_SEARCH = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0] st_q, st_d;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) st_d = ST_EXEC;
      end
      ST_EXEC: begin
        st_d = status_i.need_search ? ST_SEARCH : ST_DONE;
      end
      ST_SEARCH: begin
        st_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) st_d = ST_IDLE;
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  assign in_ready_o      = (st_q == ST_IDLE);
  assign cmd_o.latch     = (st_q == ST_IDLE) && in_valid_i;
  assign cmd_o.exec      = (st_q == ST_EXEC);
  assign cmd_o.search    = (st_q == ST_SEARCH);
  assign cmd_o.load_out  = (st_q == ST_DONE) && status_i.out_free;

endmodule
`default_nettype wire

FILE: hw/rtl/ecd_datapath.sv
// call flags, phase, floors, door counter, target search and result register
`timescale 1ns / 1ps
`default_nettype none
module ecd_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ecd_pkg::dp_cmd_t    cmd_i,
  output ecd_pkg::dp_status_t      status_o,
  input  wire logic                cfg_we_i,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [15:0]         cfg_data_i,
  input  wire logic [1:0]          command_i,
  input  wire logic [3:0]          floor_i,
  input  wire logic [3:0]          position_floor_i,
  input  wire logic                at_target_i,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output logic                     call_accepted_o,
  output logic [2:0]               motion_phase_o,
  output logic [1:0]               travel_direction_o,
  output logic [3:0]               current_floor_out_o,
  output logic [3:0]               target_floor_out_o,
  output logic                     target_valid_o,
  output logic [15:0]              pending_calls_o
);
  import ecd_pkg::*;

  // configuration
  logic [FLOOR_W-1:0] lo_q, hi_cfg_q;
  logic [15:0]        door_ticks_q;

  // latched item
  logic [1:0]         cmd_q, cmd_d;
  logic [FLOOR_W-1:0] flr_q, flr_d, pos_q, pos_d;
  logic               arr_q, arr_d;

  // dispatch state
  logic [FLOOR_COUNT-1:0] car_q, car_d, up_q, up_d, dn_q, dn_d;
  logic [1:0]             dir_q, dir_d;
  logic [2:0]             phase_q, phase_d;
  logic [FLOOR_W-1:0]     logical_q, logical_d, serviced_q, serviced_d, target_q, target_d;
  logic                   tgt_set_q, tgt_set_d;
  logic [15:0]            door_cnt_q, door_cnt_d;
  logic                   acc_q, acc_d;

  // result register
  logic out_valid_q;

  logic [FLOOR_W-1:0]     hi;
  logic [FLOOR_COUNT-1:0] all_calls;
  logic [FLOOR_COUNT-1:0] gt_cur, lt_cur, gt_srv, lt_srv, le_hi, ge_lo;
  logic                   calls_above, calls_below;
  logic [1:0]             upd_dir;
  logic                   call_ok;
  logic [FLOOR_W-1:0]     pos_sat;
  logic [15:0]            door_inc;
  logic [FLOOR_COUNT-1:0] p1, p2, p3;
  logic                   t_found;
  logic [FLOOR_W-1:0]     t_flr;

  assign hi        = (hi_cfg_q > TOP_FLOOR_INDEX) ? TOP_FLOOR_INDEX : hi_cfg_q;
  assign all_calls = car_q | up_q | dn_q;
  assign pos_sat   = (pos_q > TOP_FLOOR_INDEX) ? TOP_FLOOR_INDEX : pos_q;
  assign door_inc  = (door_cnt_q == 16'hFFFF) ? door_cnt_q : door_cnt_q + 16'd1;

  always_comb begin
    for (int i = 0; i < FLOOR_COUNT; i++) begin
      gt_cur[i] = FLOOR_W'(i) > logical_q;
      lt_cur[i] = FLOOR_W'(i) < logical_q;
      gt_srv[i] = FLOOR_W'(i) > serviced_q;
      lt_srv[i] = FLOOR_W'(i) < serviced_q;
      le_hi[i]  = FLOOR_W'(i) <= hi;
      ge_lo[i]  = FLOOR_W'(i) >= lo_q;
    end
  end

  assign calls_above = |(all_calls & gt_srv & le_hi);
  assign calls_below = |(all_calls & lt_srv & ge_lo);

  // direction review before a target search
  always_comb begin
    upd_dir = dir_q;
    if (all_calls == '0) begin
      upd_dir = DIR_IDLE;
    end else begin
      if (upd_dir == DIR_UP && !calls_above && calls_below) upd_dir = DIR_DOWN;
      if (upd_dir == DIR_DOWN) begin
        if (!calls_below && calls_above) upd_dir = DIR_UP;
      end else if (upd_dir == DIR_IDLE) begin
        if (calls_above) upd_dir = DIR_UP;
        else if (calls_below) upd_dir = DIR_DOWN;
      end
    end
  end

  assign call_ok = (flr_q >= lo_q) && (flr_q <= hi)
                && !(flr_q == serviced_q && dir_q == DIR_IDLE)
                && !(cmd_q == CMD_HALL_UP && flr_q == hi)
                && !(cmd_q == CMD_HALL_DOWN && flr_q == lo_q);

  // next stop search
  always_comb begin
    p1 = '0;
    p2 = '0;
    p3 = '0;
    t_found = 1'b0;
    t_flr = '0;
    unique case (dir_q)
      DIR_UP: begin
        p1 = (car_q | up_q) & gt_cur & le_hi;
        p2 = dn_q & gt_cur & le_hi;
        p3 = car_q & lt_cur & ge_lo;
        t_found = |{p1, p2, p3};
        priority if (|p1) t_flr = lowest_set(p1);
        else if (|p2) t_flr = highest_set(p2);
        else t_flr = highest_set(p3);
      end
      DIR_DOWN: begin
        p1 = (car_q | dn_q) & lt_cur & ge_lo;
        p2 = up_q & lt_cur & ge_lo;
        p3 = car_q & gt_cur & le_hi;
        t_found = |{p1, p2, p3};
        priority if (|p1) t_flr = highest_set(p1);
        else if (|p2) t_flr = lowest_set(p2);
        else t_flr = lowest_set(p3);
      end
      default: begin
        t_found = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd_d      = cmd_q;
    flr_d      = flr_q;
    pos_d      = pos_q;
    arr_d      = arr_q;
    car_d      = car_q;
    up_d       = up_q;
    dn_d       = dn_q;
    dir_d      = dir_q;
    phase_d    = phase_q;
    logical_d  = logical_q;
    serviced_d = serviced_q;
    target_d   = target_q;
    tgt_set_d  = tgt_set_q;
    door_cnt_d = door_cnt_q;
    acc_d      = acc_q;

    if (cmd_i.latch) begin
      cmd_d = command_i;
      flr_d = floor_i;
      pos_d = position_floor_i;
      arr_d = at_target_i;
    end

    if (cmd_i.exec) begin
      if (cmd_q == CMD_TICK) begin
        acc_d = 1'b0;
        unique case (phase_q)
          PH_IDLE: begin
            if (all_calls[logical_q]) phase_d = PH_OPENING;
            else dir_d = upd_dir;
          end
          PH_MOVING: begin
            logical_d = pos_sat;
            if (arr_q) begin
              logical_d  = target_q;
              serviced_d = target_q;
              phase_d    = PH_OPENING;
            end
          end
          PH_OPENING: begin
            car_d[logical_q] = 1'b0;
            up_d[logical_q]  = 1'b0;
            dn_d[logical_q]  = 1'b0;
            phase_d    = PH_OPEN;
            door_cnt_d = '0;
          end
          PH_OPEN: begin
            door_cnt_d = door_inc;
            if (door_inc > door_ticks_q) phase_d = PH_CLOSING;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end else begin
        acc_d = call_ok;
        if (call_ok) begin
          unique case (cmd_q)
            CMD_CAR:     car_d[flr_q] = 1'b1;
            CMD_HALL_UP: up_d[flr_q]  = 1'b1;
            default:     dn_d[flr_q]  = 1'b1;
          endcase
          if (dir_q == DIR_IDLE) begin
            if (serviced_q < flr_q) dir_d = DIR_UP;
            else if (serviced_q > flr_q) dir_d = DIR_DOWN;
          end
        end
      end
    end

    if (cmd_i.search && dir_q != DIR_IDLE) begin
      if (t_found) begin
        target_d  = t_flr;
        tgt_set_d = 1'b1;
        phase_d   = PH_MOVING;
        if (t_flr > logical_q) dir_d = DIR_UP;
        else if (t_flr < logical_q) dir_d = DIR_DOWN;
        else dir_d = DIR_IDLE;
      end else begin
        tgt_set_d = 1'b0;
        dir_d     = DIR_IDLE;
      end
    end
  end

  assign status_o.need_search = (cmd_q == CMD_TICK) && (phase_q == PH_IDLE)
                             && !all_calls[logical_q];
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q         <= '0;
      hi_cfg_q     <= 4'd15;
      door_ticks_q <= 16'd2000;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LOWEST:     lo_q         <= cfg_data_i[FLOOR_W-1:0];
        CFG_HIGHEST:    hi_cfg_q     <= cfg_data_i[FLOOR_W-1:0];
        CFG_DOOR_TICKS: door_ticks_q <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      car_q      <= '0;
      up_q       <= '0;
      dn_q       <= '0;
      dir_q      <= DIR_IDLE;
      phase_q    <= PH_IDLE;
      logical_q  <= '0;
      serviced_q <= '0;
      target_q   <= '0;
      tgt_set_q  <= 1'b0;
      door_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      car_q      <= car_d;
      up_q       <= up_d;
      dn_q       <= dn_d;
      dir_q      <= dir_d;
      phase_q    <= phase_d;
      logical_q  <= logical_d;
      serviced_q <= serviced_d;
      target_q   <= target_d;
      tgt_set_q  <= tgt_set_d;
      door_cnt_q <= door_cnt_d;
      if (cmd_i.load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    flr_q <= flr_d;
    pos_q <= pos_d;
    arr_q <= arr_d;
    acc_q <= acc_d;
    if (cmd_i.load_out) begin
      call_accepted_o     <= acc_q;
      motion_phase_o      <= phase_q;
      travel_direction_o  <= dir_q;
      current_floor_out_o <= logical_q;
      target_floor_out_o  <= target_q;
      target_valid_o      <= tgt_set_q;
      pending_calls_o     <= all_calls;
    end
  end

  assign out_valid_o = out_valid_q;

  a_target_starts_motion: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(tgt_set_q) |-> phase_q == PH_MOVING)
    else $error("target chosen without starting motion");

  a_open_clears_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_OPEN && $past(phase_q) == PH_OPENING) |-> !all_calls[logical_q])
    else $error("calls left at floor after door opened");

  a_door_count_in_door_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (door_cnt_q != $past(door_cnt_q))
      |-> ($past(phase_q) == PH_OPEN || $past(phase_q) == PH_OPENING))
    else $error("door counter moved outside door phases");

endmodule
`default_nettype wire

FILE: hw/rtl/elevator_collective_dispatch_core.sv
// elevator collective dispatch top level
//
//   channel  dir  signals                                         transfer when
//   req_i    in   command floor position_floor at_target          valid && ready
//   rsp_o    out  call_accepted motion_phase travel_direction     valid && ready
//                 current_floor_out target_floor_out target_valid pending_calls
//   cfg      in   cfg_we_i cfg_index_i cfg_data_i                 cfg_we_i
//
// a call or a tick outside the idle phase passes through exec and done, an idle-phase
// tick also through the next stop search unless a call waits at the car's floor
// the result register lets the next request transfer while a result waits
// a full result register holds the controller in its final step
// reset is asynchronous, active low; it clears all calls and control state
`timescale 1ns / 1ps
`default_nettype none
module elevator_collective_dispatch_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ecd_in_if.sink           req_i,
  ecd_out_if.source        rsp_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import ecd_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  ecd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd)
  );

  ecd_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (dp_cmd),
    .status_o            (dp_status),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .command_i           (req_i.command),
    .floor_i             (req_i.floor),
    .position_floor_i    (req_i.position_floor),
    .at_target_i         (req_i.at_target),
    .out_ready_i         (rsp_o.ready),
    .out_valid_o         (rsp_o.valid),
    .call_accepted_o     (rsp_o.call_accepted),
    .motion_phase_o      (rsp_o.motion_phase),
    .travel_direction_o  (rsp_o.travel_direction),
    .current_floor_out_o (rsp_o.current_floor_out),
    .target_floor_out_o  (rsp_o.target_floor_out),
    .target_valid_o      (rsp_o.target_valid),
    .pending_calls_o     (rsp_o.pending_calls)
  );

endmodule
`default_nettype wire

FILE: tb/tb_elevator_collective_dispatch_core.sv
// self-checking testbench for the elevator collective dispatch core
`timescale 1ns / 1ps
module tb_elevator_collective_dispatch_core;
  import ecd_pkg::*;

  localparam int NO_STOP = -1;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 165;
  localparam int SATURATION_PHASE = 5;
  localparam int OPEN_HOLD_TICKS = 40;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  phase;
    logic [1:0]  direction;
    logic [3:0]  cur_floor;
    logic [3:0]  tgt_floor;
    logic        tgt_valid;
    logic [15:0] pending;
  } car_status_t;

  typedef struct packed {
    logic        new_setting;
    logic [1:0]  cmd;
    logic [3:0]  fl;
    logic [3:0]  pos;
    logic        at;
    logic        typed;
    car_status_t status;
  } stim_row_t;

  typedef struct packed {
    logic [3:0]  lowest;
    logic [3:0]  highest;
    logic [15:0] door_ticks;
  } setting_t;

  localparam car_status_t AT_RESET = '{1'b0, PH_IDLE, DIR_IDLE, 4'd0, 4'd0, 1'b0, 16'h0000};
  localparam car_status_t UNTYPED = '0;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  ecd_in_if  req_if ();
  ecd_out_if rsp_if ();

  elevator_collective_dispatch_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // directed settings, taken in order by rows that start a new setting
  setting_t directed_settings [2] = '{
    '{4'd0, 4'd15, 16'd0},
    '{4'd5, 4'd3,  16'd0}
  };

  stim_row_t directed_rows [24] = '{
    '{1'b0, CMD_CAR,       4'd0,  4'd0,  1'b0, 1'b1, AT_RESET},
    '{1'b0, CMD_HALL_DOWN, 4'd0,  4'd0,  1'b0, 1'b1, AT_RESET},
    '{1'b0, CMD_HALL_UP,   4'd15, 4'd0,  1'b0, 1'b1, AT_RESET},
    '{1'b0, CMD_CAR,       4'd15, 4'd0,  1'b0, 1'b1,
      '{1'b1, PH_IDLE, DIR_UP, 4'd0, 4'd0, 1'b0, 16'h8000}},
    '{1'b0, CMD_HALL_DOWN, 4'd15, 4'd0,  1'b0, 1'b1,
      '{1'b1, PH_IDLE, DIR_UP, 4'd0, 4'd0, 1'b0, 16'h8000}},
    '{1'b0, CMD_HALL_UP,   4'd0,  4'd0,  1'b0, 1'b1,
      '{1'b1, PH_IDLE, DIR_UP, 4'd0, 4'd0, 1'b0, 16'h8001}},
    '{1'b0, CMD_TICK,      4'd0,  4'd0,  1'b0, 1'b0, UNTYPED},
    '{1'b0, CMD_TICK,      4'd0,  4'd0,  1'b0, 1'b0, UNTYPED},
    '{1'b0, CMD_TICK,      4'd15, 4'd15, 1'b1, 1'b0, UNTYPED},
    '{1'b1, CMD_TICK,      4'd0,  4'd0,  1'b0, 1'b0, UNTYPED},
    '{1'b0, CMD_TICK,      4'd0,  4'd0,  1'b0, 1'b0, UNTYPED},
    '{1'b0, CMD_TICK,      4'd0,  4'd0,  1'b0, 1'b0, UNTYPED},
    '{1'b0, CMD_TICK,      4'd0,  4'd15, 1'b0, 1'b0, UNTYPED},
    '{1'b0, CMD_TICK,      4'd0,  4'd7,  1'b1, 1'b0, UNTYPED},
    '{1'b0, CMD_TICK,      4'd0,  4'd0,  1'b0, 1'b0, UNTYPED},
    '{1'b0, CMD_TICK,      4'd0,  4'd0,  1'b0, 1'b0, UNTYPED},
    '{1'b0, CMD_TICK,      4'd0,  4'd0,  1'b0, 1'b0, UNTYPED},
    '{1'b0, CMD_TICK,      4'd0,  4'd0,  1'b0, 1'b0, UNTYPED},
    '{1'b0, CMD_CAR,       4'd15, 4'd0,  1'b0, 1'b1,
      '{1'b0, PH_IDLE, DIR_IDLE, 4'd15, 4'd15, 1'b1, 16'h0000}},
    '{1'b0, CMD_CAR,       4'd3,  4'd0,  1'b0, 1'b0, UNTYPED},
    '{1'b0, CMD_HALL_UP,   4'd15, 4'd0,  1'b0, 1'b1,
      '{1'b0, PH_IDLE, DIR_DOWN, 4'd15, 4'd15, 1'b1, 16'h0008}},
    '{1'b1, CMD_CAR,       4'd4,  4'd0,  1'b0, 1'b1,
      '{1'b0, PH_IDLE, DIR_DOWN, 4'd15, 4'd15, 1'b1, 16'h0008}},
    '{1'b0, CMD_TICK,      4'd0,  4'd0,  1'b0, 1'b0, UNTYPED},
    '{1'b0, CMD_HALL_DOWN, 4'd4,  4'd0,  1'b0, 1'b0, UNTYPED}
  };

  // predicted controller state
  logic [15:0] car_req = '0;
  logic [15:0] up_req = '0;
  logic [15:0] down_req = '0;
  logic [1:0]  dir_st = DIR_IDLE;
  logic [2:0]  phase_st = PH_IDLE;
  logic [3:0]  cur_floor = '0;
  logic [3:0]  svc_floor = '0;
  logic [3:0]  tgt_floor = '0;
  logic        tgt_set = 1'b0;
  logic [15:0] door_cnt = '0;
  logic [3:0]  cfg_lowest = 4'd0;
  logic [3:0]  cfg_highest = 4'd15;
  logic [15:0] cfg_door = 16'd2000;

  car_status_t car_status_q [$];
  int          fault_count = 0;
  int          stall_cycles = 0;
  bit          steady = 1'b0;
  bit          hold_request = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int served_top();
    return (int'(cfg_highest) < int'(TOP_FLOOR_INDEX)) ? int'(cfg_highest)
                                                       : int'(TOP_FLOOR_INDEX);
  endfunction

  function automatic logic [15:0] all_calls();
    return car_req | up_req | down_req;
  endfunction

  function automatic bit any_above(int f);
    logic [15:0] pend;
    pend = all_calls();
    for (int i = f + 1; i <= served_top(); i++) if (pend[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit any_below(int f);
    logic [15:0] pend;
    pend = all_calls();
    for (int i = f - 1; i >= int'(cfg_lowest); i--) if (pend[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void steer();
    int f;
    f = int'(svc_floor);
    if (all_calls() == '0) begin
      dir_st = DIR_IDLE;
      return;
    end
    if (dir_st == DIR_UP && !any_above(f) && any_below(f)) dir_st = DIR_DOWN;
    if (dir_st == DIR_DOWN) begin
      if (!any_below(f) && any_above(f)) dir_st = DIR_UP;
      return;
    end
    if (dir_st == DIR_IDLE) begin
      if (any_above(f)) dir_st = DIR_UP;
      else if (any_below(f)) dir_st = DIR_DOWN;
    end
  endfunction

  function automatic int pick_stop();
    int here;
    int lo;
    int hi;
    here = int'(cur_floor);
    lo = int'(cfg_lowest);
    hi = served_top();
    if (dir_st == DIR_UP) begin
      for (int f = here + 1; f <= hi; f++) if (car_req[f] || up_req[f]) return f;
      for (int f = hi; f > here; f--) if (down_req[f]) return f;
      for (int f = here - 1; f >= lo; f--) if (car_req[f]) return f;
    end else if (dir_st == DIR_DOWN) begin
      for (int f = here - 1; f >= lo; f--) if (car_req[f] || down_req[f]) return f;
      for (int f = lo; f < here; f++) if (up_req[f]) return f;
      for (int f = here + 1; f <= hi; f++) if (car_req[f]) return f;
    end
    return NO_STOP;
  endfunction

  function automatic bit log_call(logic [1:0] cmd, int f);
    if (f < int'(cfg_lowest) || f > served_top()) return 1'b0;
    if (f == int'(svc_floor) && dir_st == DIR_IDLE) return 1'b0;
    if (cmd == CMD_HALL_UP && f == served_top()) return 1'b0;
    if (cmd == CMD_HALL_DOWN && f == int'(cfg_lowest)) return 1'b0;
    case (cmd)
      CMD_CAR: car_req[f] = 1'b1;
      CMD_HALL_UP: up_req[f] = 1'b1;
      default: down_req[f] = 1'b1;
    endcase
    if (dir_st == DIR_IDLE) begin
      if (int'(svc_floor) < f) dir_st = DIR_UP;
      else if (int'(svc_floor) > f) dir_st = DIR_DOWN;
    end
    return 1'b1;
  endfunction

  function automatic void advance(logic [3:0] pos, logic arrived);
    logic [15:0] pend;
    int stop;
    pend = all_calls();
    case (phase_st)
      PH_IDLE: begin
        if (pend[cur_floor]) begin
          phase_st = PH_OPENING;
        end else begin
          steer();
          if (dir_st != DIR_IDLE) begin
            stop = pick_stop();
            if (stop != NO_STOP) begin
              tgt_floor = 4'(stop);
              tgt_set = 1'b1;
              phase_st = PH_MOVING;
              if (tgt_floor > cur_floor) dir_st = DIR_UP;
              else if (tgt_floor < cur_floor) dir_st = DIR_DOWN;
              else dir_st = DIR_IDLE;
            end else begin
              tgt_set = 1'b0;
              dir_st = DIR_IDLE;
            end
          end
        end
      end
      PH_MOVING: begin
        cur_floor = (pos > TOP_FLOOR_INDEX) ? TOP_FLOOR_INDEX : pos;
        if (arrived) begin
          cur_floor = tgt_floor;
          svc_floor = tgt_floor;
          phase_st = PH_OPENING;
        end
      end
      PH_OPENING: begin
        car_req[cur_floor] = 1'b0;
        up_req[cur_floor] = 1'b0;
        down_req[cur_floor] = 1'b0;
        phase_st = PH_OPEN;
        door_cnt = '0;
      end
      PH_OPEN: begin
        if (door_cnt != 16'hFFFF) door_cnt = door_cnt + 16'd1;
        if (door_cnt > cfg_door) phase_st = PH_CLOSING;
      end
      default: phase_st = PH_IDLE;
    endcase
  endfunction

  function automatic car_status_t dispatch_predict(logic [1:0] cmd, logic [3:0] fl,
                                                   logic [3:0] pos, logic at);
    car_status_t s;
    s.accepted = 1'b0;
    if (cmd == CMD_TICK) advance(pos, at);
    else s.accepted = log_call(cmd, int'(fl));
    s.phase = phase_st;
    s.direction = dir_st;
    s.cur_floor = cur_floor;
    s.tgt_floor = tgt_floor;
    s.tgt_valid = tgt_set;
    s.pending = all_calls();
    return s;
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [3:0] fl,
                           input logic [3:0] pos, input logic at,
                           input logic typed, input car_status_t typed_status);
    car_status_t s;
    req_if.valid <= 1'b1;
    req_if.command <= cmd;
    req_if.floor <= fl;
    req_if.position_floor <= pos;
    req_if.at_target <= at;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    s = dispatch_predict(cmd, fl, pos, at);
    car_status_q.push_back(typed ? typed_status : s);
  endtask

  task automatic sender_gap();
    if (!steady && $urandom_range(0, 9) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (car_status_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_LOWEST: cfg_lowest = data[3:0];
      CFG_HIGHEST: cfg_highest = data[3:0];
      CFG_DOOR_TICKS: cfg_door = data;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [3:0] lo, input logic [3:0] hi,
                           input logic [15:0] ticks);
    write_reg(CFG_LOWEST, {12'($urandom), lo});
    write_reg(CFG_HIGHEST, {12'($urandom), hi});
    write_reg(CFG_DOOR_TICKS, ticks);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // mostly ticks that let the car arrive, and calls mostly inside the served range
  task automatic send_random();
    logic [1:0] cmd;
    logic [3:0] fl;
    logic [3:0] pos;
    logic       at;
    int         pick;
    pick = $urandom_range(0, 99);
    cmd = 2'($urandom);
    fl = 4'($urandom);
    pos = 4'($urandom);
    at = 1'($urandom);
    if (pick >= 5 && pick < 35) begin
      cmd = 2'($urandom_range(0, 2));
      if (int'(cfg_lowest) <= served_top() && $urandom_range(0, 4) != 0)
        fl = 4'($urandom_range(int'(cfg_lowest), served_top()));
    end else if (pick >= 35) begin
      cmd = CMD_TICK;
      if (phase_st == PH_MOVING) begin
        at = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 1) == 0)
          pos = 4'($urandom_range(int'(cur_floor), int'(tgt_floor)));
      end
    end
    send_item(cmd, fl, pos, at, 1'b0, UNTYPED);
  endtask

  task automatic pick_setting(output logic [3:0] lo, output logic [3:0] hi,
                              output logic [15:0] ticks);
    case ($urandom_range(0, 6))
      0: begin
        lo = 4'd0;
        hi = 4'd15;
        ticks = 16'd0;
      end
      1: begin
        lo = 4'($urandom);
        hi = 4'($urandom);
        ticks = 16'($urandom_range(0, 6));
      end
      2: begin
        lo = 4'($urandom);
        hi = lo;
        ticks = 16'd1;
      end
      3: begin
        lo = 4'($urandom_range(0, 3));
        hi = 4'($urandom_range(11, 15));
        ticks = 16'($urandom_range(8, 40));
      end
      default: begin
        lo = 4'($urandom_range(0, 3));
        hi = 4'($urandom_range(11, 15));
        ticks = 16'($urandom_range(0, 3));
      end
    endcase
  endtask

  initial begin
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_request) begin
        rsp_if.ready <= 1'b0;
        repeat (150) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (!steady && $urandom_range(0, 7) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk_i) begin : status_check
    car_status_t want;
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (rsp_if.valid && rsp_if.ready) begin
        if (car_status_q.size() == 0) begin
          $error("result transfer with no expected status");
          fault_count++;
        end else begin
          want = car_status_q.pop_front();
          check_field("call_accepted", want.accepted, rsp_if.call_accepted);
          check_field("motion_phase", want.phase, rsp_if.motion_phase);
          check_field("travel_direction", want.direction, rsp_if.travel_direction);
          check_field("current_floor_out", want.cur_floor, rsp_if.current_floor_out);
          check_field("target_floor_out", want.tgt_floor, rsp_if.target_floor_out);
          check_field("target_valid", want.tgt_valid, rsp_if.target_valid);
          check_field("pending_calls", want.pending, rsp_if.pending_calls);
        end
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [3:0]  lo;
    logic [3:0]  hi;
    logic [15:0] ticks;
    int          setting_idx;
    int          tries;
    req_if.valid <= 1'b0;
    req_if.command <= CMD_TICK;
    req_if.floor <= '0;
    req_if.position_floor <= '0;
    req_if.at_target <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= CFG_LOWEST;
    cfg_data_i <= '0;
    setting_idx = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].new_setting) begin
        settle();
        configure(directed_settings[setting_idx].lowest,
                  directed_settings[setting_idx].highest,
                  directed_settings[setting_idx].door_ticks);
        setting_idx++;
      end
      send_item(directed_rows[i].cmd, directed_rows[i].fl, directed_rows[i].pos,
                directed_rows[i].at, directed_rows[i].typed, directed_rows[i].status);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      if (p == 0) begin
        lo = 4'd0;
        hi = 4'd15;
        ticks = 16'd1;
      end else begin
        pick_setting(lo, hi, ticks);
      end
      if (p == SATURATION_PHASE) begin
        configure(4'd0, 4'd15, 16'hFFFF);
        tries = 0;
        while (phase_st != PH_OPEN && tries < 400) begin
          sender_gap();
          send_random();
          tries++;
        end
        if (phase_st == PH_OPEN) begin
          // with the longest open time the door stays open tick after tick
          steady = 1'b1;
          repeat (OPEN_HOLD_TICKS) send_item(CMD_TICK, 4'($urandom), 4'($urandom),
                                             1'($urandom), 1'b0, UNTYPED);
          steady = 1'b0;
        end
        settle();
        ticks = 16'd2;
      end
      configure(lo, hi, ticks);
      steady = (p == RANDOM_PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 0 && n == 10) hold_request = 1'b1;
        sender_gap();
        send_random();
      end
    end

    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (car_status_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (fault_count == 0 && car_status_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
